@@ hdl/rtc_pkg.sv @@
package rtc_pkg;

    // Day counter width; alarm day fields stay 16 bits wide
    localparam int DAY_BITS = 16;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Register groups of four words, selected by reg_index[4:2]
    localparam logic [2:0] GRP_CNT   = 3'd0;
    localparam logic [2:0] GRP_TUPD  = 3'd1;
    localparam logic [2:0] GRP_AUPD  = 3'd2;
    localparam logic [2:0] GRP_ALARM = 3'd4;
    localparam logic [2:0] GRP_AUX   = 3'd6;

    // Field index within a group
    localparam logic [1:0] FLD_SEC  = 2'd0;
    localparam logic [1:0] FLD_MIN  = 2'd1;
    localparam logic [1:0] FLD_HOUR = 2'd2;
    localparam logic [1:0] FLD_DAY  = 2'd3;

    // Single registers
    localparam logic [4:0] REG_IEN       = 5'd12;
    localparam logic [4:0] REG_RAW       = 5'd13;
    localparam logic [4:0] REG_CLR       = 5'd14;
    localparam logic [4:0] REG_MSK       = 5'd15;
    localparam logic [4:0] REG_GUARD     = 5'd20;
    localparam logic [4:0] REG_GUARD_UPD = 5'd21;
    localparam logic [4:0] REG_PWR_CTL   = 5'd22;
    localparam logic [4:0] REG_PWR_STS   = 5'd23;

    // Pending mark for the guard update
    localparam logic [3:0] PM_GUARD = 4'd8;

    localparam logic [5:0] SEC_LAST   = 6'd59;
    localparam logic [5:0] MIN_LAST   = 6'd59;
    localparam logic [4:0] HOUR_LAST  = 5'd23;
    localparam logic [7:0] UNLOCK_KEY = 8'hA5;
    localparam logic [7:0] PWR_RESET  = 8'h96;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  reg_index;
        logic [15:0] write_data;
    } rtc_in_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        irq_line;
        logic        power_up_event;
    } rtc_out_t;

    function automatic logic [15:0] field_mask(input logic [1:0] fld);
        logic [15:0] m;
        unique case (fld)
            FLD_SEC:  m = 16'h003F;
            FLD_MIN:  m = 16'h003F;
            FLD_HOUR: m = 16'h001F;
            default:  m = 16'hFFFF;
        endcase
        return m;
    endfunction

endpackage

@@ hdl/rtc_in_stage.sv @@
module rtc_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rtc_pkg::rtc_in_t s_item,
    input  logic            take,
    output logic            item_valid,
    output rtc_pkg::rtc_in_t item
);
    import rtc_pkg::*;

    logic    valid_reg;
    rtc_in_t item_reg;

    // Free when empty or when the held item moves on this cycle
    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

@@ hdl/rtc_regs.sv @@
module rtc_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  rtc_pkg::rtc_in_t  item,
    output rtc_pkg::rtc_out_t result
);
    import rtc_pkg::*;

    logic [5:0]          sec_reg,   sec_next;
    logic [5:0]          min_reg,   min_next;
    logic [4:0]          hours_reg, hours_next;
    logic [DAY_BITS-1:0] day_reg,   day_next;
    logic [15:0]         alarm_reg  [4], alarm_next  [4];
    logic [15:0]         aux_reg    [4], aux_next    [4];
    logic [15:0]         ptime_reg  [4], ptime_next  [4];
    logic [15:0]         palarm_reg [4], palarm_next [4];
    logic [8:0]          pmark_reg, pmark_next;
    logic [15:0]         ien_reg,   ien_next;
    logic [15:0]         raw_reg,   raw_next;
    logic [8:0]          guard_reg, guard_next;
    logic [8:0]          gpend_reg, gpend_next;
    logic [7:0]          pwr_reg,   pwr_next;

    logic [2:0]  grp;
    logic [1:0]  sub;
    logic [15:0] rd_mux;

    assign grp = item.reg_index[4:2];
    assign sub = item.reg_index[1:0];

    // Register read selection
    always_comb begin
        rd_mux = 16'h0000;
        if (grp == GRP_CNT) begin
            unique case (sub)
                FLD_SEC:  rd_mux = {10'b0, sec_reg};
                FLD_MIN:  rd_mux = {10'b0, min_reg};
                FLD_HOUR: rd_mux = {11'b0, hours_reg};
                default:  rd_mux = 16'(day_reg);
            endcase
        end else if (grp == GRP_ALARM) begin
            rd_mux = alarm_reg[sub];
        end else if (grp == GRP_AUX) begin
            rd_mux = aux_reg[sub];
        end else if (item.reg_index == REG_IEN) begin
            rd_mux = ien_reg;
        end else if (item.reg_index == REG_RAW) begin
            rd_mux = raw_reg;
        end else if (item.reg_index == REG_MSK) begin
            rd_mux = raw_reg & ien_reg;
        end else if (item.reg_index == REG_GUARD) begin
            rd_mux = {7'b0, guard_reg};
        end else if (item.reg_index == REG_PWR_STS) begin
            rd_mux = {8'b0, pwr_reg};
        end
    end

    always_comb begin
        logic [15:0] ev;
        logic        alarm_hit;
        logic        aux_hit;
        logic [15:0] rd;
        logic        pwr_up;

        sec_next   = sec_reg;
        min_next   = min_reg;
        hours_next = hours_reg;
        day_next   = day_reg;
        alarm_next  = alarm_reg;
        aux_next    = aux_reg;
        ptime_next  = ptime_reg;
        palarm_next = palarm_reg;
        pmark_next = pmark_reg;
        ien_next   = ien_reg;
        raw_next   = raw_reg;
        guard_next = guard_reg;
        gpend_next = gpend_reg;
        pwr_next   = pwr_reg;
        ev         = 16'h0000;
        alarm_hit  = 1'b0;
        aux_hit    = 1'b0;
        rd         = 16'h0000;
        pwr_up     = 1'b0;

        if (fire) begin
            unique case (item.op)
                OP_READ: begin
                    rd = rd_mux;
                end
                OP_WRITE: begin
                    if (grp == GRP_TUPD) begin
                        ptime_next[sub] = item.write_data & field_mask(sub);
                        pmark_next[{2'b00, sub}] = 1'b1;
                    end else if (grp == GRP_AUPD) begin
                        palarm_next[sub] = item.write_data & field_mask(sub);
                        pmark_next[{2'b01, sub}] = 1'b1;
                    end else if (grp == GRP_AUX) begin
                        aux_next[sub] = item.write_data & field_mask(sub);
                    end else if (item.reg_index == REG_IEN) begin
                        ien_next = item.write_data;
                    end else if (item.reg_index == REG_CLR) begin
                        raw_next = raw_reg & ~item.write_data;
                    end else if (item.reg_index == REG_GUARD_UPD) begin
                        gpend_next = item.write_data[8:0];
                        pmark_next[PM_GUARD] = 1'b1;
                    end else if (item.reg_index == REG_PWR_CTL) begin
                        pwr_next = (pwr_reg & ~item.write_data[7:0])
                                 | item.write_data[15:8];
                    end
                end
                OP_TICK: begin
                    // Advance one second, carrying through the fields
                    ev[0] = 1'b1;
                    if (sec_reg >= SEC_LAST) begin
                        sec_next = 6'd0;
                        ev[1]    = 1'b1;
                        if (min_reg >= MIN_LAST) begin
                            min_next = 6'd0;
                            ev[2]    = 1'b1;
                            if (hours_reg >= HOUR_LAST) begin
                                hours_next = 5'd0;
                                ev[3]      = 1'b1;
                                day_next   = day_reg + DAY_BITS'(1);
                            end else begin
                                hours_next = hours_reg + 5'd1;
                            end
                        end else begin
                            min_next = min_reg + 6'd1;
                        end
                    end else begin
                        sec_next = sec_reg + 6'd1;
                    end

                    // Load pending updates over the advanced count
                    if (pmark_reg[0]) begin
                        sec_next = ptime_reg[FLD_SEC][5:0];
                    end
                    if (pmark_reg[1]) begin
                        min_next = ptime_reg[FLD_MIN][5:0];
                    end
                    if (pmark_reg[2]) begin
                        hours_next = ptime_reg[FLD_HOUR][4:0];
                    end
                    if (pmark_reg[3]) begin
                        day_next = DAY_BITS'(ptime_reg[FLD_DAY]);
                    end
                    ev[11:8] = pmark_reg[3:0];
                    for (int i = 0; i < 4; i++) begin
                        if (pmark_reg[4+i]) begin
                            alarm_next[i] = palarm_reg[i];
                        end
                    end
                    ev[15:12] = pmark_reg[7:4];
                    if (pmark_reg[PM_GUARD]) begin
                        guard_next = gpend_reg;
                        ev[7]      = 1'b1;
                    end
                    pmark_next = 9'd0;

                    alarm_hit = ({10'b0, sec_next}   == alarm_next[FLD_SEC])
                             && ({10'b0, min_next}   == alarm_next[FLD_MIN])
                             && ({11'b0, hours_next} == alarm_next[FLD_HOUR])
                             && (32'(day_next) == 32'(alarm_next[FLD_DAY]));
                    aux_hit   = ({10'b0, sec_next}   == aux_next[FLD_SEC])
                             && ({10'b0, min_next}   == aux_next[FLD_MIN])
                             && ({11'b0, hours_next} == aux_next[FLD_HOUR])
                             && (32'(day_next) == 32'(aux_next[FLD_DAY]));
                    ev[4]  = alarm_hit;
                    ev[6]  = aux_hit;
                    pwr_up = alarm_hit && (guard_next[7:0] == UNLOCK_KEY);
                    raw_next = raw_reg | ev;
                end
                default: begin
                end
            endcase
        end

        result.read_data      = rd;
        result.irq_line       = |(raw_next & ien_next);
        result.power_up_event = pwr_up;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_reg   <= 6'd0;
            min_reg   <= 6'd0;
            hours_reg <= 5'd0;
            day_reg   <= '0;
            for (int i = 0; i < 4; i++) begin
                alarm_reg[i]  <= 16'h0000;
                aux_reg[i]    <= 16'h0000;
                ptime_reg[i]  <= 16'h0000;
                palarm_reg[i] <= 16'h0000;
            end
            pmark_reg <= 9'd0;
            ien_reg   <= 16'h0000;
            raw_reg   <= 16'h0000;
            guard_reg <= 9'd0;
            gpend_reg <= 9'd0;
            pwr_reg   <= PWR_RESET;
        end else begin
            sec_reg    <= sec_next;
            min_reg    <= min_next;
            hours_reg  <= hours_next;
            day_reg    <= day_next;
            alarm_reg  <= alarm_next;
            aux_reg    <= aux_next;
            ptime_reg  <= ptime_next;
            palarm_reg <= palarm_next;
            pmark_reg  <= pmark_next;
            ien_reg    <= ien_next;
            raw_reg    <= raw_next;
            guard_reg  <= guard_next;
            gpend_reg  <= gpend_next;
            pwr_reg    <= pwr_next;
        end
    end

    a_tick_sets_second: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.op == OP_TICK |=> raw_reg[0])
        else $error("second tick status bit not raised");

    a_tick_drains_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.op == OP_TICK |=> pmark_reg == 9'd0)
        else $error("pending updates survived a tick");

    a_reserved_status: assert property (@(posedge aclk) disable iff (!aresetn)
        !raw_reg[5])
        else $error("reserved status bit set");

    a_power_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        result.power_up_event |-> fire && item.op == OP_TICK
                                  && guard_next[7:0] == UNLOCK_KEY)
        else $error("power-up event outside an unlocked tick");

endmodule

@@ hdl/rtc_day_hour_min_sec_with_alarms_unit.sv @@
// Real-time clock with a normal and an auxiliary alarm behind 28 word registers. Each
// input item is a register read, a register write or a one-second tick, and each item
// yields exactly one result item carrying read data, the interrupt line level after the
// item, and a power-up flag for a normal-alarm match while the alarm guard is unlocked
// (low byte 0xa5). Items are taken at a rate of one per cycle while the receiver keeps
// up: an input register feeds a single pass of counter, compare and register-file
// logic, and the result is captured in an output register as its item leaves the input
// register, then leaves once the receiver is ready. A result held by the receiver keeps
// the next item in the input register, which in turn holds off the sender. Writes to
// the time, alarm and guard update registers are held and take effect on the next tick,
// raising their update status bits. The status register clears by writing ones. After
// reset all state is zero except power status, which reads 0x96 (time invalid).
module rtc_day_hour_min_sec_with_alarms_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rtc_pkg::rtc_in_t   s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output rtc_pkg::rtc_out_t  m_item
);
    import rtc_pkg::*;

    logic     item_valid;
    rtc_in_t  item;
    logic     take;
    rtc_out_t result;
    logic     m_valid_reg;
    rtc_out_t m_item_reg;

    // Move the held item through the register file when the result slot is free
    // or is being emptied this cycle; this keeps one item per cycle under flow.
    assign take = item_valid && (!m_valid_reg || m_ready);

    // Input register: hold the accepted item until the core consumes it
    rtc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Clock state, alarms, status and the single-pass update logic
    rtc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (take),
        .item    (item),
        .result  (result)
    );

    // Result register: capture on every consumed item, drop once delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_item_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // A consumed item always refills the result slot on the next edge
    a_take_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> m_valid)
        else $error("consumed item produced no result");

    // Never consume while a result is stalled
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !take)
        else $error("stalled result overwritten");

    // A held item with no room waits in the input register
    a_held_item_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid && m_valid && !m_ready |=> item_valid)
        else $error("input item lost during stall");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the real-time clock with alarms. Items go in through a
// valid/ready channel; every accepted item is also applied to a behavioural copy of
// the clock, and the reply it should produce is queued. A checker process compares
// each reply from the unit, field by field, against the oldest queued one.
module testbench;
    import rtc_pkg::*;

    // The unused op code must read back zero and change nothing
    localparam logic [1:0] OP_SPARE     = 2'd3;
    // Last word of the unmapped hole at the top of the register map
    localparam logic [4:0] REG_UNMAPPED = 5'd31;

    // Raw status bit positions
    localparam int ST_SEC      = 0;
    localparam int ST_MIN      = 1;
    localparam int ST_HOUR     = 2;
    localparam int ST_DAY      = 3;
    localparam int ST_ALARM    = 4;
    localparam int ST_AUX      = 6;
    localparam int ST_GUARD    = 7;
    localparam int ST_TIME_LD  = 8;
    localparam int ST_ALARM_LD = 12;

    // Alarm sets held by the clock copy
    localparam int SET_MAIN = 0;
    localparam int SET_AUX  = 1;

    localparam logic [31:0] DAY_MASK = 32'((64'd1 << DAY_BITS) - 64'd1);
    localparam int CYCLE_LIMIT = 400_000;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    rtc_in_t  s_item  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    rtc_out_t m_item;

    // Behavioural copy of the clock state
    logic [31:0] clock_now [4];
    logic [15:0] alarm_set [2][4];
    logic [15:0] staged_time [4];
    logic [15:0] staged_alarm [4];
    logic [8:0]  staged_marks;
    logic [15:0] irq_enable;
    logic [15:0] status_raw;
    logic [8:0]  guard_word;
    logic [8:0]  guard_staged;
    logic [7:0]  power_flags;

    // Replies still owed by the unit, oldest first
    rtc_out_t replies_due [$];

    int send_idle_pct = 31;
    int recv_idle_pct = 76;
    int items_sent    = 0;
    int tick_items    = 0;
    int read_items    = 0;
    int write_items   = 0;
    int spare_items   = 0;
    int power_up_seen = 0;
    int irq_seen      = 0;
    int mismatch_count = 0;
    int cycles_run    = 0;

    rtc_day_hour_min_sec_with_alarms_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #5 aclk = ~aclk;

    // Bits a field keeps when it is written
    function automatic logic [15:0] keep_bits(input logic [1:0] fld);
        case (fld)
            FLD_SEC, FLD_MIN: return 16'h003f;
            FLD_HOUR:         return 16'h001f;
            default:          return 16'hffff;
        endcase
    endfunction

    // All four fields of an alarm set equal the running count (day in full width)
    function automatic logic alarm_hit(input int which);
        logic hit;
        int i;
        hit = 1'b1;
        for (i = 0; i < 4; i++) begin
            if (clock_now[i] != {16'b0, alarm_set[which][i]})
                hit = 1'b0;
        end
        return hit;
    endfunction

    // Apply one item to the clock copy and return the reply it should produce
    function automatic rtc_out_t rtc_item_effect(input rtc_in_t it);
        rtc_out_t res;
        logic [2:0] grp;
        logic [1:0] fld;
        logic [15:0] raised;
        int i;
        res = '0;
        grp = it.reg_index[4:2];
        fld = it.reg_index[1:0];
        raised = '0;
        case (it.op)
            OP_READ: begin
                if (grp == GRP_CNT)
                    res.read_data = clock_now[fld][15:0];
                else if (grp == GRP_ALARM)
                    res.read_data = alarm_set[SET_MAIN][fld];
                else if (grp == GRP_AUX)
                    res.read_data = alarm_set[SET_AUX][fld];
                else if (it.reg_index == REG_IEN)
                    res.read_data = irq_enable;
                else if (it.reg_index == REG_RAW)
                    res.read_data = status_raw;
                else if (it.reg_index == REG_MSK)
                    res.read_data = status_raw & irq_enable;
                else if (it.reg_index == REG_GUARD)
                    res.read_data = {7'b0, guard_word};
                else if (it.reg_index == REG_PWR_STS)
                    res.read_data = {8'b0, power_flags};
            end
            OP_WRITE: begin
                if (grp == GRP_TUPD) begin
                    staged_time[fld] = it.write_data & keep_bits(fld);
                    staged_marks[fld] = 1'b1;
                end else if (grp == GRP_AUPD) begin
                    staged_alarm[fld] = it.write_data & keep_bits(fld);
                    staged_marks[4 + fld] = 1'b1;
                end else if (grp == GRP_AUX) begin
                    alarm_set[SET_AUX][fld] = it.write_data & keep_bits(fld);
                end else if (it.reg_index == REG_IEN) begin
                    irq_enable = it.write_data;
                end else if (it.reg_index == REG_CLR) begin
                    status_raw = status_raw & ~it.write_data;
                end else if (it.reg_index == REG_GUARD_UPD) begin
                    guard_staged = it.write_data[8:0];
                    staged_marks[PM_GUARD] = 1'b1;
                end else if (it.reg_index == REG_PWR_CTL) begin
                    power_flags = (power_flags & ~it.write_data[7:0]) | it.write_data[15:8];
                end
            end
            OP_TICK: begin
                // Advance by one second; anything at or past its last value wraps and carries
                raised[ST_SEC] = 1'b1;
                if (clock_now[FLD_SEC] >= SEC_LAST) begin
                    clock_now[FLD_SEC] = '0;
                    raised[ST_MIN] = 1'b1;
                    if (clock_now[FLD_MIN] >= MIN_LAST) begin
                        clock_now[FLD_MIN] = '0;
                        raised[ST_HOUR] = 1'b1;
                        if (clock_now[FLD_HOUR] >= HOUR_LAST) begin
                            clock_now[FLD_HOUR] = '0;
                            raised[ST_DAY] = 1'b1;
                            clock_now[FLD_DAY] = (clock_now[FLD_DAY] + 1) & DAY_MASK;
                        end else begin
                            clock_now[FLD_HOUR]++;
                        end
                    end else begin
                        clock_now[FLD_MIN]++;
                    end
                end else begin
                    clock_now[FLD_SEC]++;
                end
                // Then load staged updates; no staged field can exceed the day mask
                for (i = 0; i < 4; i++) begin
                    if (staged_marks[i]) begin
                        clock_now[i] = {16'b0, staged_time[i]} & DAY_MASK;
                        raised[ST_TIME_LD + i] = 1'b1;
                    end
                    if (staged_marks[4 + i]) begin
                        alarm_set[SET_MAIN][i] = staged_alarm[i];
                        raised[ST_ALARM_LD + i] = 1'b1;
                    end
                end
                if (staged_marks[PM_GUARD]) begin
                    guard_word = guard_staged;
                    raised[ST_GUARD] = 1'b1;
                end
                staged_marks = '0;
                // Compare last, against the freshly loaded values
                if (alarm_hit(SET_MAIN)) begin
                    raised[ST_ALARM] = 1'b1;
                    res.power_up_event = (guard_word[7:0] == UNLOCK_KEY);
                end
                if (alarm_hit(SET_AUX))
                    raised[ST_AUX] = 1'b1;
                status_raw = status_raw | raised;
            end
            default: begin
            end
        endcase
        res.irq_line = |(status_raw & irq_enable);
        return res;
    endfunction

    // Offer one item, hold it until taken, then queue the reply it should cause
    task automatic send_rtc_item(input logic [1:0] op, input logic [4:0] idx,
                                 input logic [15:0] data);
        rtc_in_t it;
        it.op = op;
        it.reg_index = idx;
        it.write_data = data;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        replies_due.push_back(rtc_item_effect(it));
        items_sent++;
        case (op)
            OP_READ:  read_items++;
            OP_WRITE: write_items++;
            OP_TICK:  tick_items++;
            default:  spare_items++;
        endcase
    endtask

    // Field value biased towards wrap points, sometimes with stray high bits
    function automatic logic [15:0] field_value(input logic [1:0] fld);
        logic [15:0] v;
        case (fld)
            FLD_SEC, FLD_MIN:
                v = $urandom_range(1) ? 16'($urandom_range(63, 56)) : 16'($urandom_range(63));
            FLD_HOUR:
                v = $urandom_range(1) ? 16'($urandom_range(31, 21)) : 16'($urandom_range(31));
            default:
                v = 16'($urandom_range(1)) ^ ($urandom_range(1) ? 16'hffff : 16'h0000);
        endcase
        if ($urandom_range(4) == 0)
            v = 16'($urandom_range(65535));
        return v;
    endfunction

    // Any item at all: random op, any of the 32 indexes, random data
    task automatic send_noise_item;
        logic [1:0] op;
        logic [4:0] idx;
        logic [15:0] data;
        int pick;
        pick = $urandom_range(99);
        idx = 5'($urandom_range(31));
        data = 16'($urandom_range(65535));
        if (pick < 35)
            op = OP_TICK;
        else if (pick < 62)
            op = OP_READ;
        else if (pick < 95)
            op = OP_WRITE;
        else
            op = OP_SPARE;
        if (op == OP_WRITE && $urandom_range(2) != 0 &&
            (idx[4:2] == GRP_TUPD || idx[4:2] == GRP_AUPD || idx[4:2] == GRP_AUX))
            data = field_value(idx[1:0]);
        send_rtc_item(op, idx, data);
    endtask

    // Set the time, arm the alarm and maybe the aux alarm up to three seconds ahead, maybe unlock, then tick through
    task automatic arm_alarm_sequence;
        logic [15:0] written [4];
        logic [15:0] base [4];
        logic [15:0] data;
        logic [1:0] f;
        int lead, aux_lead, i, pick;
        lead = $urandom_range(3);
        aux_lead = $urandom_range(3);
        for (i = 0; i < 4; i++) begin
            f = 2'(i);
            written[i] = field_value(f);
            base[i] = written[i] & keep_bits(f);
        end
        if ($urandom_range(1))
            send_rtc_item(OP_WRITE, REG_IEN, 16'($urandom_range(65535)));
        for (i = 0; i < 4; i++)
            send_rtc_item(OP_WRITE, {GRP_TUPD, 2'(i)}, written[i]);
        for (i = 0; i < 4; i++) begin
            data = (i == 0) ? ((base[0] + 16'(lead)) & 16'h003f) : base[i];
            send_rtc_item(OP_WRITE, {GRP_AUPD, 2'(i)}, data);
        end
        if ($urandom_range(1)) begin
            for (i = 0; i < 4; i++) begin
                data = (i == 0) ? ((base[0] + 16'(aux_lead)) & 16'h003f) : base[i];
                send_rtc_item(OP_WRITE, {GRP_AUX, 2'(i)}, data);
            end
        end
        pick = $urandom_range(3);
        if (pick < 2)
            send_rtc_item(OP_WRITE, REG_GUARD_UPD,
                          {$urandom_range(127) == 0 ? 7'h7f : 7'h00, 1'($urandom_range(1)),
                           UNLOCK_KEY});
        else if (pick == 2)
            send_rtc_item(OP_WRITE, REG_GUARD_UPD, 16'($urandom_range(65535)));
        repeat ((lead > aux_lead ? lead : aux_lead) + 2) begin
            send_rtc_item(OP_TICK, 5'($urandom_range(31)), 16'($urandom_range(65535)));
            if ($urandom_range(1))
                send_rtc_item(OP_READ, $urandom_range(1) ? REG_RAW : 5'($urandom_range(31)),
                              16'h0000);
            if ($urandom_range(3) == 0)
                send_rtc_item(OP_WRITE, REG_CLR, 16'($urandom_range(65535)));
        end
    endtask

    // Reset pattern of power status, the unused op, the unmapped hole, a read-only write
    task automatic test_reset_state;
        send_rtc_item(OP_READ, REG_PWR_STS, 16'h0000);
        send_rtc_item(OP_SPARE, REG_PWR_STS, 16'hffff);
        send_rtc_item(OP_READ, REG_UNMAPPED, 16'hffff);
        send_rtc_item(OP_WRITE, REG_RAW, 16'hffff);
    endtask

    // Load the last second of the last day, roll over every field at once and
    // hit the all-zero alarms with the guard unlocked
    task automatic test_rollover_and_unlock;
        send_rtc_item(OP_WRITE, REG_IEN, 16'hffff);
        send_rtc_item(OP_WRITE, {GRP_TUPD, FLD_SEC}, 16'hffff);
        send_rtc_item(OP_WRITE, {GRP_TUPD, FLD_MIN}, 16'd59);
        send_rtc_item(OP_WRITE, {GRP_TUPD, FLD_HOUR}, 16'd5);
        send_rtc_item(OP_WRITE, {GRP_TUPD, FLD_HOUR}, 16'd23);
        send_rtc_item(OP_WRITE, {GRP_TUPD, FLD_DAY}, 16'hffff);
        send_rtc_item(OP_WRITE, {GRP_AUPD, FLD_SEC}, 16'h0000);
        send_rtc_item(OP_WRITE, {GRP_AUPD, FLD_MIN}, 16'h0000);
        send_rtc_item(OP_WRITE, {GRP_AUPD, FLD_HOUR}, 16'h0000);
        send_rtc_item(OP_WRITE, {GRP_AUPD, FLD_DAY}, 16'h0000);
        send_rtc_item(OP_WRITE, REG_GUARD_UPD, {7'h00, 1'b1, UNLOCK_KEY});
        send_rtc_item(OP_TICK, '0, 16'h0000);
        send_rtc_item(OP_TICK, '1, 16'hffff);
        send_rtc_item(OP_READ, {GRP_CNT, FLD_DAY}, 16'h0000);
    endtask

    // Masked status, write-one-to-clear, power control set and clear, aux alarm mask
    task automatic test_status_and_power;
        send_rtc_item(OP_READ, REG_MSK, 16'h0000);
        send_rtc_item(OP_WRITE, REG_CLR, 16'h00ff);
        send_rtc_item(OP_READ, REG_RAW, 16'h0000);
        send_rtc_item(OP_WRITE, REG_PWR_CTL, 16'hff00);
        send_rtc_item(OP_WRITE, REG_PWR_CTL, 16'h00ff);
        send_rtc_item(OP_READ, REG_PWR_STS, 16'h0000);
        send_rtc_item(OP_WRITE, {GRP_AUX, FLD_SEC}, 16'hffff);
        send_rtc_item(OP_READ, {GRP_AUX, FLD_SEC}, 16'h0000);
    endtask

    // Mostly armed-alarm sequences with random content, the rest noise
    task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
                                       input int quota);
        int first;
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        first = items_sent;
        while (items_sent - first < quota) begin
            if ($urandom_range(99) < 55)
                arm_alarm_sequence();
            else
                repeat ($urandom_range(8, 1)) send_noise_item();
        end
    endtask

    // Check each reply taken by the receiver against the oldest one owed, then
    // decide whether to stall the next cycle
    always @(posedge aclk) begin : reply_check
        rtc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                $error("unexpected reply %h with nothing owed", m_item);
                mismatch_count++;
            end else begin
                want = replies_due.pop_front();
                if (m_item.read_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data, m_item.read_data);
                    mismatch_count++;
                end
                if (m_item.irq_line !== want.irq_line) begin
                    $error("irq_line: expected %b, got %b", want.irq_line, m_item.irq_line);
                    mismatch_count++;
                end
                if (m_item.power_up_event !== want.power_up_event) begin
                    $error("power_up_event: expected %b, got %b",
                           want.power_up_event, m_item.power_up_event);
                    mismatch_count++;
                end
                if (m_item.power_up_event === 1'b1)
                    power_up_seen++;
                if (m_item.irq_line === 1'b1)
                    irq_seen++;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: give up if the run stalls
    initial begin
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles_run++;
        end
        $display("rtc_day_hour_min_sec_with_alarms_unit verification failed");
        $finish;
    end

    initial begin
        int i;
        // Initialise the clock copy to its reset state: everything zero, alarm
        // locked, power status showing invalid time
        for (i = 0; i < 4; i++) begin
            clock_now[i] = '0;
            alarm_set[SET_MAIN][i] = '0;
            alarm_set[SET_AUX][i] = '0;
            staged_time[i] = '0;
            staged_alarm[i] = '0;
        end
        staged_marks = '0;
        irq_enable = '0;
        status_raw = '0;
        guard_word = '0;
        guard_staged = '0;
        power_flags = PWR_RESET;

        // Hold reset, then release it for good
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_rollover_and_unlock();
        test_status_and_power();

        // Sender sparse with a busy receiver, then the reverse, then flat out
        test_random_traffic(31, 76, 667);
        test_random_traffic(76, 31, 667);
        test_random_traffic(0, 0, 667);

        // Drop valid and drain; a reply is valid in the cycle after its item is
        // taken, so leave a margin for strays
        s_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Covered %0d ticks, %0d reads, %0d writes and %0d unused-op items",
                 tick_items, read_items, write_items, spare_items);
        $display("under three idle mixes; %0d power-up events and %0d interrupt replies seen.",
                 power_up_seen, irq_seen);
        if (mismatch_count == 0)
            $display("rtc_day_hour_min_sec_with_alarms_unit verification clean");
        else
            $display("rtc_day_hour_min_sec_with_alarms_unit verification failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/rtc_pkg.sv
hdl/rtc_in_stage.sv
hdl/rtc_regs.sv
hdl/rtc_day_hour_min_sec_with_alarms_unit.sv
tb/testbench.sv
